@@ hw/rtl/kcc_pkg.sv @@
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared constants and types for the key click classifier.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int NUM_KEYS     = 4;
  localparam int CNT_W        = 8;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [CNT_W-1:0] LONG_RST       = CNT_W'(30);
  localparam logic [CNT_W-1:0] WINDOW_RST     = CNT_W'(25);

  localparam logic [CFG_IDX_W-1:0] REG_LONG   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(1);

  typedef struct packed {
    logic single_click;
    logic double_click;
    logic long_press;
  } kcc_evt_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] window_ticks;
  } kcc_cfg_t;

endpackage

@@ hw/rtl/kcc_lane.sv @@
// ----------------------------------------------------------------------------
// kcc_lane
// One key: debounce, hold counter, double-click window and event decode.
// ----------------------------------------------------------------------------
module kcc_lane
  import kcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     level_i,
  input  kcc_cfg_t cfg_i,
  output kcc_evt_t evt_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_CONF  = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] hold_q, hold_d;
  logic             wopen_q, wopen_d;
  logic [CNT_W-1:0] wcnt_q, wcnt_d;
  logic             wopen_mid;
  logic [CNT_W-1:0] wcnt_mid;

  always_comb begin
    phase_d   = phase_q;
    hold_d    = hold_q;
    wopen_mid = wopen_q;
    wcnt_mid  = wcnt_q;
    evt_o     = '0;

    unique case (phase_q)
      PH_FIRST: begin
        phase_d = level_i ? PH_IDLE : PH_CONF;
      end
      PH_CONF: begin
        if (level_i) begin
          if (hold_q < cfg_i.long_ticks) begin
            if (!wopen_q) begin
              wopen_mid = 1'b1;
              wcnt_mid  = '0;
            end else begin
              evt_o.double_click = 1'b1;
              wopen_mid          = 1'b0;
            end
          end else begin
            evt_o.long_press = 1'b1;
          end
          phase_d = PH_IDLE;
        end else if (hold_q != CNT_MAX) begin
          hold_d = hold_q + CNT_W'(1);
        end
      end
      default: begin
        if (!level_i) begin
          phase_d = PH_FIRST;
          hold_d  = '0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase

    wopen_d = wopen_mid;
    wcnt_d  = wcnt_mid;
    if (wopen_mid) begin
      if (wcnt_mid >= cfg_i.window_ticks) begin
        evt_o.single_click = 1'b1;
        wopen_d            = 1'b0;
      end else if (wcnt_mid != CNT_MAX) begin
        wcnt_d = wcnt_mid + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hold_q  <= '0;
      wopen_q <= 1'b0;
      wcnt_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      wopen_q <= wopen_d;
      wcnt_q  <= wcnt_d;
    end
  end

endmodule

@@ hw/rtl/kcc_merge.sv @@
// ----------------------------------------------------------------------------
// kcc_merge
// Gathers lane events into per-tick masks and holds them in the output stage.
// ----------------------------------------------------------------------------
module kcc_merge
  import kcc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  kcc_evt_t [NUM_KEYS-1:0] evt_i,
  input  logic                   take_i,
  output logic                   valid_o,
  output logic [NUM_KEYS-1:0]    single_o,
  output logic [NUM_KEYS-1:0]    double_o,
  output logic [NUM_KEYS-1:0]    long_o
);

  logic                valid_q;
  logic [NUM_KEYS-1:0] single_d, double_d, long_d;
  logic [NUM_KEYS-1:0] single_q, double_q, long_q;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      single_d[k] = evt_i[k].single_click;
      double_d[k] = evt_i[k].double_click;
      long_d[k]   = evt_i[k].long_press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      single_q <= single_d;
      double_q <= double_d;
      long_q   <= long_d;
    end
  end

  assign valid_o  = valid_q;
  assign single_o = single_q;
  assign double_o = double_q;
  assign long_o   = long_q;

endmodule

@@ hw/rtl/key_click_classifier_top.sv @@
// ----------------------------------------------------------------------------
// key_click_classifier_top
// Single, double and long press detection for four active-low keys.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata[3:0] key_levels
//  m_axis    out  tvalid/tready          tdata[3:0] single, [7:4] double, [11:8] long
//  cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
//  One tick request per cycle unless the output stalls; its masks appear in the
//  cycle after acceptance. Each key lane updates in the accepting cycle; the output
//  register holds the masks, and a new request is taken whenever that register is
//  empty or being drained. Reset clears all lanes and loads thresholds 30 and 25.
// ----------------------------------------------------------------------------
module key_click_classifier_top
  import kcc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [3:0] key_levels
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [3:0] single, [7:4] double, [11:8] long
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CNT_W-1:0]       cfg_data_i
);

  kcc_cfg_t                cfg_q;
  kcc_evt_t [NUM_KEYS-1:0] evt;
  logic                    step;
  logic                    out_valid;
  logic [NUM_KEYS-1:0]     single_mask, double_mask, long_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ticks   <= LONG_RST;
      cfg_q.window_ticks <= WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LONG:   cfg_q.long_ticks   <= cfg_data_i;
        REG_WINDOW: cfg_q.window_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !out_valid || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kcc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step),
      .level_i (s_axis_tdata_i[k]),
      .cfg_i   (cfg_q),
      .evt_o   (evt[k])
    );
  end

  kcc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .evt_i    (evt),
    .take_i   (m_axis_tready_i),
    .valid_o  (out_valid),
    .single_o (single_mask),
    .double_o (double_mask),
    .long_o   (long_mask)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 3*NUM_KEYS)'(0), long_mask, double_mask, single_mask};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key click classifier. Scan ticks go in on the
// slave stream and a predictor tracks every key lane and works out the
// single, double and long event masks of each tick. The masks that come back
// on the master stream are compared field by field, in order. A short table
// of directed ticks runs first. Random press and release scripts follow,
// one per key, under several threshold settings that include zero and 255.
// Both stream sides idle at random, and there is one long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
  import kcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD_OFF  = 64;
  localparam int NUM_PHASES     = 9;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_FIRST_LOW = 2'd1,
    PH_HELD      = 2'd2,
    PH_UNUSED    = 2'd3
  } lane_phase_e;

  typedef struct packed {
    logic [3:0] single_m;
    logic [3:0] double_m;
    logic [3:0] long_m;
  } masks_t;

  typedef struct {
    logic [3:0] levels;
    bit         fixed;
    masks_t     masks;
  } tick_row_t;

  typedef struct {
    int long_thr;
    int win_len;
    int n_ticks;
  } thr_phase_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CNT_W-1:0]       cfg_data;

  // predictor state
  logic [CNT_W-1:0] long_thr;
  logic [CNT_W-1:0] win_len;
  lane_phase_e      lane_phase [NUM_KEYS];
  logic [CNT_W-1:0] hold_ticks [NUM_KEYS];
  logic             win_open   [NUM_KEYS];
  logic [CNT_W-1:0] win_ticks  [NUM_KEYS];

  masks_t expected_masks_q[$];

  // random key scripts
  logic lane_level [NUM_KEYS];
  int   lane_run   [NUM_KEYS];

  int  mismatch_cnt;
  int  idle_cycles;
  int  rcv_hold_req;
  bit  snd_steady;
  bit  rcv_steady;

  key_click_classifier_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [3:0] key_levels
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [3:0] single, [7:4] double, [11:8] long
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  function automatic void reset_lanes();
    long_thr = LONG_RST;
    win_len  = WINDOW_RST;
    for (int k = 0; k < NUM_KEYS; k++) begin
      lane_phase[k] = PH_IDLE;
      hold_ticks[k] = '0;
      win_open[k]   = 1'b0;
      win_ticks[k]  = '0;
      lane_level[k] = 1'b1;
      lane_run[k]   = 0;
    end
  endfunction

  function automatic masks_t classify_tick(input logic [3:0] levels);
    masks_t m;
    logic   up;
    m = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      up = levels[k];
      case (lane_phase[k])
        PH_FIRST_LOW: begin
          lane_phase[k] = up ? PH_IDLE : PH_HELD;
        end
        PH_HELD: begin
          if (up) begin
            if (hold_ticks[k] < long_thr) begin
              if (!win_open[k]) begin
                win_open[k]  = 1'b1;
                win_ticks[k] = '0;
              end else begin
                m.double_m[k] = 1'b1;
                win_open[k]   = 1'b0;
              end
            end else begin
              m.long_m[k] = 1'b1;
            end
            lane_phase[k] = PH_IDLE;
          end else if (hold_ticks[k] != CNT_MAX) begin
            hold_ticks[k]++;
          end
        end
        default: begin
          if (!up) begin
            lane_phase[k] = PH_FIRST_LOW;
            hold_ticks[k] = '0;
          end else begin
            lane_phase[k] = PH_IDLE;
          end
        end
      endcase
      if (win_open[k]) begin
        if (win_ticks[k] >= win_len) begin
          m.single_m[k] = 1'b1;
          win_open[k]   = 1'b0;
        end else if (win_ticks[k] != CNT_MAX) begin
          win_ticks[k]++;
        end
      end
    end
    return m;
  endfunction

  // press lengths straddle the long threshold, release gaps the window
  function automatic logic [3:0] next_scan();
    logic [3:0] lv;
    int         r;
    int         lt;
    int         wl;
    lt = int'(long_thr);
    wl = int'(win_len);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (lane_run[k] == 0) begin
        lane_level[k] = ~lane_level[k];
        r = $urandom_range(0, 9);
        if (!lane_level[k]) begin
          if (r == 0)      lane_run[k] = 1;
          else if (r <= 5) lane_run[k] = $urandom_range(2, lt + 1);
          else if (r <= 8) lane_run[k] = $urandom_range(lt + 2, lt + 4);
          else             lane_run[k] = $urandom_range(258, 300);
        end else begin
          if (r <= 4)      lane_run[k] = $urandom_range(1, wl + 1);
          else if (r <= 7) lane_run[k] = $urandom_range(wl + 1, wl + 4);
          else             lane_run[k] = $urandom_range(1, 3);
        end
      end
      lane_run[k]--;
      lv[k] = lane_level[k];
    end
    if ($urandom_range(0, 19) == 0) begin
      lv ^= 4'($urandom_range(1, 15));
    end
    return lv;
  endfunction

  // entered and left on a falling edge
  task automatic send_tick(input logic [3:0] levels, input bit fixed, input masks_t fixed_m);
    int     gap;
    masks_t m;
    gap = snd_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(levels);
    do @(posedge clk_i); while (!s_tready);
    m = classify_tick(levels);
    expected_masks_q.push_back(fixed ? fixed_m : m);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_masks_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_thresholds(input logic [CNT_W-1:0] lt, input logic [CNT_W-1:0] wl);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_LONG;
    cfg_data <= lt;
    @(negedge clk_i);
    cfg_idx  <= REG_WINDOW;
    cfg_data <= wl;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    long_thr = lt;
    win_len  = wl;
  endtask

  // receiver
  initial begin
    int     stall;
    masks_t want;
    masks_t got;
    m_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rcv_hold_req > 0) begin
        stall        = rcv_hold_req;
        rcv_hold_req = 0;
      end else begin
        stall = rcv_steady ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      got.single_m = m_tdata[3:0];
      got.double_m = m_tdata[7:4];
      got.long_m   = m_tdata[11:8];
      if (expected_masks_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h", m_tdata));
      end else begin
        want = expected_masks_q.pop_front();
        if (got.single_m !== want.single_m)
          report_mismatch($sformatf("single mask %h, want %h", got.single_m, want.single_m));
        if (got.double_m !== want.double_m)
          report_mismatch($sformatf("double mask %h, want %h", got.double_m, want.double_m));
        if (got.long_m !== want.long_m)
          report_mismatch($sformatf("long mask %h, want %h", got.long_m, want.long_m));
        if (m_tdata[OUT_TDATA_W-1:12] !== '0)
          report_mismatch($sformatf("padding bits set, tdata=%h", m_tdata));
      end
      @(negedge clk_i);
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    tick_row_t  rows[$];
    thr_phase_t phases[NUM_PHASES];
    int         n;

    rst_ni       = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    rcv_hold_req = 0;
    snd_steady   = 1'b0;
    rcv_steady   = 1'b0;
    reset_lanes();

    // levels, fixed, {single, double, long}
    rows = '{
      '{4'hF, 1'b1, '0},              // all released after reset
      '{4'hE, 1'b1, '0},              // key 0 first low
      '{4'hF, 1'b1, '0},              // one-tick glitch rejected
      '{4'h0, 1'b1, '0},              // all first low
      '{4'h0, 1'b0, '0},
      '{4'hF, 1'b0, '0},              // short release, windows open
      '{4'h5, 1'b0, '0},
      '{4'h5, 1'b0, '0},
      '{4'h5, 1'b0, '0},
      '{4'hF, 1'b0, '0},              // double click on keys 1 and 3
      '{4'hA, 1'b0, '0},
      '{4'hA, 1'b0, '0},
      '{4'hF, 1'b0, '0},              // double click on keys 0 and 2
      '{4'h3, 1'b0, '0},
      '{4'hC, 1'b0, '0},              // keys 2,3 glitch, keys 0,1 first low
      '{4'hC, 1'b0, '0},
      '{4'hF, 1'b0, '0},
      '{4'h6, 1'b0, '0},
      '{4'h9, 1'b0, '0},
      '{4'hF, 1'b0, '0}
    };

    phases = '{
      '{30, 25, 140},
      '{0, 0, 140},                   // every release long, window closes at once
      '{1, 1, 160},
      '{255, 255, 500},               // counter limits
      '{3, 5, 160},
      '{8, 2, 160},
      '{255, 0, 120},
      '{0, 255, 120},
      '{-1, -1, 160}                  // drawn at random
    };

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      send_tick(rows[i].levels, rows[i].fixed, rows[i].masks);
    end
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (phases[p].long_thr < 0) begin
        set_thresholds(CNT_W'($urandom_range(0, 12)), CNT_W'($urandom_range(0, 12)));
      end else begin
        set_thresholds(CNT_W'(phases[p].long_thr), CNT_W'(phases[p].win_len));
      end
      snd_steady = ($urandom_range(0, 2) == 0);
      rcv_steady = ($urandom_range(0, 2) == 0);
      n = phases[p].n_ticks;
      for (int t = 0; t < n; t++) begin
        if (p == 4 && t == 20) begin
          snd_steady   = 1'b1;
          rcv_hold_req = LONG_HOLD_OFF;
        end
        if (p == 4 && t == 60) begin
          snd_steady = 1'b0;
        end
        if (p == 2 && t == n / 2) begin
          drain_results();
        end
        send_tick(next_scan(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
